### rtl/hdm_pkg.sv
// ----------------------------------------------------------------------------
// hdm_pkg
// Shared types, constants and small helper functions for the holonomic drive
// mixer.
// ----------------------------------------------------------------------------
package hdm_pkg;

  // Largest wheel power magnitude
  localparam int POWER_MAX = 127;

  // Stick sample after axis conditioning
  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [7:0] turn;
  } sample_t;

  // Magnitude of a 9-bit value that lies in -128..128
  function automatic logic [7:0] abs9(input logic signed [8:0] v);
    logic signed [8:0] m;
    begin
      m = v[8] ? -v : v;
      return m[7:0];
    end
  endfunction

  // True when the direction of (b, a) lies strictly within 15 degrees of the
  // positive b axis: t = 2b - |a| > 0 and t*t > 3*b*b
  function automatic logic near_axis(input logic signed [8:0] a,
                                     input logic signed [8:0] b);
    logic signed [10:0] t;
    logic [7:0]         bm;
    logic [15:0]        bb;
    logic [17:0]        bb3;
    logic [17:0]        tt;
    begin
      t   = 11'(signed'({b, 1'b0})) - 11'(signed'({3'b000, abs9(a)}));
      bm  = b[7:0];
      bb  = bm * bm;
      bb3 = {2'b00, bb} + {1'b0, bb, 1'b0};
      tt  = 18'(t[8:0] * t[8:0]);
      if (b[8] || (b == 9'sd0) || t[10] || (t == 11'sd0)) begin
        return 1'b0;
      end
      return tt > bb3;
    end
  endfunction

endpackage

### rtl/holonomic_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// holonomic_drive_mixer_unit
// Mixes one joystick sample into four X-drive / mecanum wheel powers through
// a pipelined snap test, bit-per-stage divider and square root.
// ----------------------------------------------------------------------------
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------
//   cfg      | cfg_valid / cfg_ready        | reverse_direction
//   sample   | sample_valid / sample_stall  | stick_x, stick_y, turn_amount
//   power    | power_valid / power_stall    | left/right front/back power
//
// One sample enters per cycle while sample_stall is low; each passes the input
// register, the snap register, the square-root stages, which resolve one result
// bit per stage, the multiply register and the output register. A stall on the
// power side holds only the stages that are full; empty stages keep filling. rst
// is synchronous and clears all valid bits and rev. cfg_ready is always high.
// ----------------------------------------------------------------------------
module holonomic_drive_mixer_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              reverse_direction,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic signed [7:0] stick_x,
  input  logic signed [7:0] stick_y,
  input  logic signed [7:0] turn_amount,
  output logic              power_valid,
  input  logic              power_stall,
  output logic signed [7:0] left_front_power,
  output logic signed [7:0] right_front_power,
  output logic signed [7:0] left_back_power,
  output logic signed [7:0] right_back_power
);

  localparam int F   = ANGLE_BITS;
  localparam int QW  = F + 1;          // quotient width, holds 2^F
  localparam int R   = F + 8;          // root width
  localparam int NW  = 2 * R;          // radicand width
  localparam int FW2 = 2 * F;
  localparam int PW  = 2 * F + 11;     // product width
  localparam int NS  = R + 4;          // register stages with a valid bit

  localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic signed [7:0] turn;
    logic              snap;
    logic              fs_neg;
    logic              fc_neg;
    logic              div_fs;
    logic [8:0]        den;
    logic [8:0]        r;
    logic [QW-1:0]     q;
    logic [15:0]       s;
    logic [R+1:0]      srem;
    logic [R-1:0]      root;
  } it_t;

  typedef struct packed {
    logic signed [7:0]    turn;
    logic signed [PW-1:0] pfs;
    logic signed [PW-1:0] pfc;
  } mul_t;

  logic                rev;
  logic [NS-1:0]       vld;
  logic [NS-1:0]       vld_in;
  logic [NS-1:0]       rdy;
  logic [NS-1:0]       ld;
  hdm_pkg::sample_t    in_q;
  hdm_pkg::sample_t    in_next;
  it_t                 it_q [0:R];
  it_t                 cls_next;
  mul_t                mul_q;
  mul_t                mul_next;

  // Add turn, truncate toward zero after dropping 2F fraction bits, then clamp
  function automatic logic signed [7:0] wheel(input logic signed [PW-1:0] p,
                                              input logic signed [8:0] t);
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] hi;
    begin
      sum = p + (PW'(t) <<< FW2);
      hi  = sum >>> FW2;
      if (sum[PW-1] && (sum[FW2-1:0] != '0)) begin
        hi = hi + PW'(1);
      end
      if (hi > PW'(hdm_pkg::POWER_MAX)) begin
        hi = PW'(hdm_pkg::POWER_MAX);
      end else if (hi < -PW'(hdm_pkg::POWER_MAX)) begin
        hi = -PW'(hdm_pkg::POWER_MAX);
      end
      return hi[7:0];
    end
  endfunction

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rev <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      rev <= reverse_direction;
    end
  end

  // Ready chain: a stage takes a request when empty or when it moves on
  assign vld_in = {vld[NS-2:0], sample_valid};
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || !power_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end
  assign ld           = rdy & vld_in;
  assign sample_stall = !rdy[0];
  assign power_valid  = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: condition axes (negate y, apply reverse)
  always_comb begin
    in_next.x    = {stick_x[7], stick_x};
    in_next.y    = -{stick_y[7], stick_y};
    in_next.turn = turn_amount;
    if (rev) begin
      in_next.x = -in_next.x;
      in_next.y = -in_next.y;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      in_q <= in_next;
    end
  end

  // Stage 1: snap tests, divider setup, radicand
  always_comb begin
    logic signed [9:0] d1;
    logic signed [9:0] d2;
    logic [8:0]        a1;
    logic [8:0]        a2;
    logic [7:0]        ax;
    logic [7:0]        ay;
    logic              zero;
    d1   = 10'(in_q.y) - 10'(in_q.x);
    d2   = 10'(in_q.x) + 10'(in_q.y);
    a1   = d1[9] ? 9'(-d1) : d1[8:0];
    a2   = d2[9] ? 9'(-d2) : d2[8:0];
    ax   = hdm_pkg::abs9(in_q.x);
    ay   = hdm_pkg::abs9(in_q.y);
    zero = (in_q.x == 9'sd0) && (in_q.y == 9'sd0);

    cls_next        = '0;
    cls_next.turn   = in_q.turn;
    cls_next.s      = 16'(ax * ax) + 16'(ay * ay);
    cls_next.den    = 9'd1;
    cls_next.snap   = 1'b1;
    if (zero || hdm_pkg::near_axis(in_q.y, in_q.x)) begin
      cls_next.fs_neg = 1'b1;
      cls_next.fc_neg = 1'b0;
    end else if (hdm_pkg::near_axis(in_q.x, in_q.y)) begin
      cls_next.fs_neg = 1'b0;
      cls_next.fc_neg = 1'b0;
    end else if (hdm_pkg::near_axis(in_q.x, -in_q.y)) begin
      cls_next.fs_neg = 1'b1;
      cls_next.fc_neg = 1'b1;
    end else if (hdm_pkg::near_axis(in_q.y, -in_q.x)) begin
      cls_next.fs_neg = 1'b0;
      cls_next.fc_neg = 1'b1;
    end else begin
      // Larger of |d1|, |d2| is the unit; divide the other by it
      cls_next.snap   = 1'b0;
      cls_next.fs_neg = d1[9];
      cls_next.fc_neg = d2[9];
      if (a1 > a2) begin
        cls_next.den    = a1;
        cls_next.r      = a2;
        cls_next.div_fs = 1'b0;
      end else begin
        cls_next.den    = a2;
        cls_next.r      = a1;
        cls_next.div_fs = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      it_q[0] <= cls_next;
    end
  end

  // Iteration stages: one root bit each; one quotient bit each in the first QW
  for (genvar j = 1; j <= R; j++) begin : g_step
    it_t step_next;

    always_comb begin
      logic [9:0]    cand;
      logic          ge;
      logic [NW-1:0] nv;
      logic [R+1:0]  rc;
      logic [R+1:0]  trial;
      step_next = it_q[j-1];
      cand      = '0;
      ge        = 1'b0;
      if (j <= QW) begin
        cand = (j == 1) ? {1'b0, it_q[j-1].r} : {it_q[j-1].r, 1'b0};
        ge   = cand >= {1'b0, it_q[j-1].den};
        step_next.r = ge ? 9'(cand - {1'b0, it_q[j-1].den}) : cand[8:0];
        step_next.q = {it_q[j-1].q[QW-2:0], ge};
      end
      nv    = {it_q[j-1].s, {FW2{1'b0}}};
      rc    = {it_q[j-1].srem[R-1:0], nv[2*(R-j)+1 -: 2]};
      trial = {it_q[j-1].root, 2'b01};
      if (rc >= trial) begin
        step_next.srem = rc - trial;
        step_next.root = {it_q[j-1].root[R-2:0], 1'b1};
      end else begin
        step_next.srem = rc;
        step_next.root = {it_q[j-1].root[R-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        it_q[j] <= step_next;
      end
    end
  end

  // Multiply stage: magnitude times each factor
  always_comb begin
    logic [QW-1:0]       fsm;
    logic [QW-1:0]       fcm;
    logic signed [F+1:0] fsv;
    logic signed [F+1:0] fcv;
    logic signed [R:0]   magv;
    fsm  = (!it_q[R].snap && it_q[R].div_fs) ? it_q[R].q : ONE_Q;
    fcm  = (!it_q[R].snap && !it_q[R].div_fs) ? it_q[R].q : ONE_Q;
    fsv  = it_q[R].fs_neg ? -$signed({1'b0, fsm}) : $signed({1'b0, fsm});
    fcv  = it_q[R].fc_neg ? -$signed({1'b0, fcm}) : $signed({1'b0, fcm});
    magv = $signed({1'b0, it_q[R].root});
    mul_next.turn = it_q[R].turn;
    mul_next.pfs  = PW'(magv * fsv);
    mul_next.pfc  = PW'(magv * fcv);
  end

  always_ff @(posedge clk) begin
    if (ld[R+2]) begin
      mul_q <= mul_next;
    end
  end

  // Output register: add or subtract turn, truncate, saturate
  always_ff @(posedge clk) begin
    if (ld[R+3]) begin
      left_front_power  <= wheel(mul_q.pfs, 9'(mul_q.turn));
      right_front_power <= wheel(mul_q.pfc, -9'(mul_q.turn));
      left_back_power   <= wheel(mul_q.pfc, 9'(mul_q.turn));
      right_back_power  <= wheel(mul_q.pfs, -9'(mul_q.turn));
    end
  end

  // Sample side stalls only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (&vld))
    else $error("sample stalled with an empty stage");

  // Divider leaves a remainder below the divisor and a quotient up to one
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[R+1] |-> (it_q[R].r < it_q[R].den) && (it_q[R].q <= ONE_Q))
    else $error("divider out of range");

  // Wheel powers stay inside the saturation range
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    power_valid |-> (left_front_power != -8'sd128) && (right_front_power != -8'sd128)
                 && (left_back_power != -8'sd128) && (right_back_power != -8'sd128))
    else $error("wheel power not saturated");

endmodule
